// ===== sv/fixed_point_q24_8_alu_defines.svh =====
// Assertion macros for the fixed-point ALU, used by the fpa_back module
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define FPA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fpa assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define FPA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fpa assertion failed");
`else
`define FPA_ASSERT_IMP(lbl, pre, post)
`define FPA_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== sv/fpa_pkg.sv =====
// Shared constants, opcodes and pipeline types of the fixed-point ALU
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DATA_W     = 32;
    // quotient bits resolved per divider stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_BITS   = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEP - 1) / DIV_STEP;
    // dividend padded with leading zeros to a whole number of stages
    localparam int DIV_NW     = DIV_STAGES * DIV_STEP;

    localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_FROM = 4'd8,
        OP_TO   = 4'd9,
        OP_CMP  = 4'd10
    } op_t;

    // restoring divider working set: partial remainder, dividend/quotient shifter
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DIV_NW-1:0] num;
        logic [DATA_W-1:0] divisor;
    } div_state_t;

    // one request as it travels down the pipeline
    typedef struct packed {
        logic [3:0]          op;
        logic [DATA_W-1:0]   simple;
        logic [2*DATA_W-1:0] prod;
        logic                is_less;
        logic                is_equal;
        logic                is_greater;
        logic                div_zero;
        logic                div_neg;
        div_state_t          div;
    } item_t;

    // unsigned magnitude placed as the widened dividend
    function automatic logic [DIV_NW-1:0] div_dividend(logic [DATA_W-1:0] mag);
        return DIV_NW'(mag) << FRAC_BITS;
    endfunction

endpackage

// ===== sv/fpa_in_if.sv =====
// Request channel of the fixed-point ALU: opcode and two operands
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b,
                    output ready);
endinterface

// ===== sv/fpa_out_if.sv =====
// Result channel of the fixed-point ALU: result word and flags
interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               divide_by_zero;

    modport source (output valid, output result, output is_less, output is_equal,
                    output is_greater, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input is_less, input is_equal,
                    input is_greater, input divide_by_zero, output ready);
endinterface

// ===== sv/fpa_front.sv =====
// First pipeline stage: decode, simple ops, compare, multiply, divider setup
module fpa_front (
    input  logic            clk,
    input  logic            rst_n,
    fpa_in_if.sink          cmd,
    output fpa_pkg::item_t  out_item,
    output logic            out_valid,
    input  logic            out_ready
);

    logic signed [fpa_pkg::DATA_W-1:0]   a;
    logic signed [fpa_pkg::DATA_W-1:0]   b;
    logic        [fpa_pkg::DATA_W-1:0]   ua;
    logic        [fpa_pkg::DATA_W-1:0]   ub;
    logic        [fpa_pkg::DATA_W-1:0]   abs_a;
    logic        [fpa_pkg::DATA_W-1:0]   abs_b;
    logic signed [2*fpa_pkg::DATA_W-1:0] prod;
    logic                                load;
    logic                                valid_reg;
    fpa_pkg::item_t                      item_reg;
    fpa_pkg::item_t                      item_next;

    assign a  = cmd.operand_a;
    assign b  = cmd.operand_b;
    assign ua = cmd.operand_a;
    assign ub = cmd.operand_b;

    // magnitudes for the unsigned divider
    assign abs_a = ua[fpa_pkg::DATA_W-1] ? (~ua + 32'd1) : ua;
    assign abs_b = ub[fpa_pkg::DATA_W-1] ? (~ub + 32'd1) : ub;

    // full signed product, shifted in the last stage
    assign prod = a * b;

    // next item: everything but mul/div is finished here
    always_comb
    begin
        item_next            = '0;
        item_next.op         = cmd.op;
        item_next.prod       = prod;
        item_next.is_less    = (a < b);
        item_next.is_equal   = (a == b);
        item_next.is_greater = (a > b);
        item_next.div_zero   = (cmd.op == fpa_pkg::OP_DIV) && (ub == '0);
        item_next.div_neg    = ua[fpa_pkg::DATA_W-1] ^ ub[fpa_pkg::DATA_W-1];
        item_next.div.rem     = '0;
        item_next.div.num     = fpa_pkg::div_dividend(abs_a);
        item_next.div.divisor = abs_b;
        case (cmd.op)
            fpa_pkg::OP_ADD:  item_next.simple = ua + ub;
            fpa_pkg::OP_SUB:  item_next.simple = ua - ub;
            fpa_pkg::OP_MIN:  item_next.simple = (a <= b) ? ua : ub;
            fpa_pkg::OP_MAX:  item_next.simple = (a >= b) ? ua : ub;
            fpa_pkg::OP_INC:  item_next.simple = ua + 32'd1;
            fpa_pkg::OP_DEC:  item_next.simple = ua - 32'd1;
            fpa_pkg::OP_FROM: item_next.simple = ua << fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_TO:   item_next.simple = a >>> fpa_pkg::FRAC_BITS;
            default:          item_next.simple = '0;
        endcase
    end

    // stage handshake: load when empty or moving on
    assign load      = !valid_reg || out_ready;
    assign cmd.ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && cmd.valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item  = item_reg;
    assign out_valid = valid_reg;

endmodule

// ===== sv/fpa_div_stage.sv =====
// One divider stage: DIV_STEP restoring division steps, other fields pass along
module fpa_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  fpa_pkg::item_t  in_item,
    input  logic            in_valid,
    output logic            in_ready,
    output fpa_pkg::item_t  out_item,
    output logic            out_valid,
    input  logic            out_ready
);

    logic [fpa_pkg::DATA_W:0]   part;
    logic [fpa_pkg::DATA_W:0]   diff;
    logic [fpa_pkg::DATA_W-1:0] rem;
    logic [fpa_pkg::DIV_NW-1:0] num;
    logic                       qbit;
    logic                       load;
    logic                       valid_reg;
    fpa_pkg::item_t             item_reg;
    fpa_pkg::item_t             item_next;

    // each step: shift in one dividend bit, subtract divisor when it fits
    always_comb
    begin
        item_next = in_item;
        rem       = in_item.div.rem;
        num       = in_item.div.num;
        part      = '0;
        diff      = '0;
        qbit      = 1'b0;
        for (int k = 0; k < fpa_pkg::DIV_STEP; k++)
        begin
            part = {rem, num[fpa_pkg::DIV_NW-1]};
            diff = part - {1'b0, in_item.div.divisor};
            qbit = !diff[fpa_pkg::DATA_W];
            rem  = qbit ? diff[fpa_pkg::DATA_W-1:0] : part[fpa_pkg::DATA_W-1:0];
            num  = {num[fpa_pkg::DIV_NW-2:0], qbit};
        end
        item_next.div.rem = rem;
        item_next.div.num = num;
    end

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item  = item_reg;
    assign out_valid = valid_reg;

endmodule

// ===== sv/fpa_back.sv =====
// Last stage: product scaling, quotient sign, result select, output register
`include "fixed_point_q24_8_alu_defines.svh"

module fpa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fpa_pkg::item_t  in_item,
    input  logic            in_valid,
    output logic            in_ready,
    fpa_out_if.source       res
);

    logic [fpa_pkg::DATA_W-1:0] mul_res;
    logic [fpa_pkg::DATA_W-1:0] quot;
    logic [fpa_pkg::DATA_W-1:0] div_res;
    logic [fpa_pkg::DATA_W-1:0] result_next;
    logic [fpa_pkg::DATA_W-1:0] result_reg;
    logic                       is_less_reg;
    logic                       is_equal_reg;
    logic                       is_greater_reg;
    logic                       div_zero_reg;
    logic                       valid_reg;
    logic                       load;

    // arithmetic shift of the product, low word kept
    assign mul_res = in_item.prod[fpa_pkg::FRAC_BITS +: fpa_pkg::DATA_W];

    // quotient truncated toward zero; zero divisor gives zero
    assign quot    = in_item.div.num[fpa_pkg::DATA_W-1:0];
    assign div_res = in_item.div_zero ? '0 : (in_item.div_neg ? (~quot + 32'd1) : quot);

    always_comb
    begin
        case (in_item.op)
            fpa_pkg::OP_MUL: result_next = mul_res;
            fpa_pkg::OP_DIV: result_next = div_res;
            default:         result_next = in_item.simple;
        endcase
    end

    // output register parts the pipeline from the consumer
    assign load     = !valid_reg || res.ready;
    assign in_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            result_reg     <= result_next;
            is_less_reg    <= in_item.is_less;
            is_equal_reg   <= in_item.is_equal;
            is_greater_reg <= in_item.is_greater;
            div_zero_reg   <= in_item.div_zero;
        end
    end

    assign res.valid          = valid_reg;
    assign res.result         = result_reg;
    assign res.is_less        = is_less_reg;
    assign res.is_equal       = is_equal_reg;
    assign res.is_greater     = is_greater_reg;
    assign res.divide_by_zero = div_zero_reg;

    // checks
    `FPA_ASSERT_IMP(a_flags_onehot, valid_reg, $onehot({is_less_reg, is_equal_reg, is_greater_reg}))
    `FPA_ASSERT_IMP(a_dz_zero_result, valid_reg && div_zero_reg, result_reg == '0)
    `FPA_ASSERT_IMP(a_div_self_is_one, in_valid && (in_item.op == fpa_pkg::OP_DIV) && in_item.is_equal && !in_item.div_zero, div_res == fpa_pkg::FIX_ONE)
    `FPA_ASSERT_NXT(a_load_shows_valid, in_valid && load, valid_reg)

endmodule

// ===== sv/fixed_point_q24_8_alu.sv =====
// Each request passes the front register, the divider stage registers and the output register.
// Throughput: one request per cycle while results are taken, sustained by the pipelined restoring divider,
// DIV_STEP quotient bits per stage, each stage with its own valid bit.
// A held result stalls only the stages behind it; bubbles still fill.
// Reset (rst_n, async, active low) clears the valid bits; data registers keep no reset.
module fixed_point_q24_8_alu (
    input  logic      clk,
    input  logic      rst_n,
    fpa_in_if.sink    cmd,
    fpa_out_if.source res
);

    fpa_pkg::item_t stage_item  [0:fpa_pkg::DIV_STAGES];
    logic           stage_valid [0:fpa_pkg::DIV_STAGES];
    logic           stage_ready [0:fpa_pkg::DIV_STAGES];

    // decode, simple ops, multiply and divider setup
    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_item  (stage_item[0]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0])
    );

    // divider pipeline
    for (genvar s = 0; s < fpa_pkg::DIV_STAGES; s++)
    begin : g_div
        fpa_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_item   (stage_item[s]),
            .in_valid  (stage_valid[s]),
            .in_ready  (stage_ready[s]),
            .out_item  (stage_item[s+1]),
            .out_valid (stage_valid[s+1]),
            .out_ready (stage_ready[s+1])
        );
    end

    // result select and output register
    fpa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (stage_item[fpa_pkg::DIV_STAGES]),
        .in_valid (stage_valid[fpa_pkg::DIV_STAGES]),
        .in_ready (stage_ready[fpa_pkg::DIV_STAGES]),
        .res      (res)
    );

endmodule
